/* rtl/dda_pkg.sv */
package dda_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COLOR_BITS     = 4;

  // Request kinds carried on in_tuser
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Line setup sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

endpackage

/* rtl/dda_line_rasterizer_core.sv */
// Channel  | Ports                       | Contents
// ---------+-----------------------------+-------------------------------------------
// in       | in_tvalid/tready/tdata/tuser| start/advance request, endpoints, color
// out      | out_tvalid/tready/tdata/tlast| one pixel, tlast marks the end of the line
//
// An advance request's pixel is registered at the accept edge.
// A start request emits the start pixel at once, then one shared divider works out
// the x and y increments in turn; in_tready stays low after a start with distinct
// endpoints until both increments are written.
// rst_n is synchronous, active low, and leaves the block idle with no line active.
// A stalled out_tready holds the pixel register and, with it, in_tready.
module dda_line_rasterizer_core #(
  parameter  int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter  int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_x, start_y, end_x, end_y, line_color (low to high), zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // req_type
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y, pixel_color (low to high), zero fill
  output logic [OUT_W-1:0] out_tdata,
  // last_pixel
  output logic             out_tlast
);

  localparam int C     = COORD_BITS;
  localparam int CB    = dda_pkg::COLOR_BITS;
  localparam int ACC_W = COORD_BITS + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int PIX_W = 2 * COORD_BITS + dda_pkg::COLOR_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  dda_pkg::state_t state_r, state_nxt;

  logic [ACC_W-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [INC_W-1:0] inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic [C:0]       steps_left_r, steps_left_nxt;
  logic [CB-1:0]    color_r, color_nxt;
  logic             active_r, active_nxt;
  logic             neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [C-1:0]     mag_y_r, mag_y_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_last_r, out_last_nxt;

  logic [C-1:0]     x1, y1, x2, y2;
  logic [CB-1:0]    color_in;
  logic [C-1:0]     ax, ay, steps;
  logic             accept;
  logic [ACC_W-1:0] sum_x, sum_y, rnd_x, rnd_y;
  logic [C:0]       steps_dec;

  logic             div_start, div_done;
  logic [C-1:0]     div_mag, div_den;
  logic [FRAC_BITS:0] div_quot;
  logic [INC_W-1:0] quot_ext, quot_signed;
  logic             quot_neg;

  // Unpack request fields
  assign x1       = in_tdata[C-1:0];
  assign y1       = in_tdata[2*C-1:C];
  assign x2       = in_tdata[3*C-1:2*C];
  assign y2       = in_tdata[4*C-1:3*C];
  assign color_in = in_tdata[4*C+CB-1:4*C];

  assign in_tready = (state_r == dda_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Line setup: magnitudes and step count
  always_comb begin
    ax    = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    ay    = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    steps = (ax > ay) ? ax : ay;
  end

  // Pixel advance: step the accumulators, round half up
  always_comb begin
    sum_x     = acc_x_r + {{(ACC_W-INC_W){inc_x_r[INC_W-1]}}, inc_x_r};
    sum_y     = acc_y_r + {{(ACC_W-INC_W){inc_y_r[INC_W-1]}}, inc_y_r};
    rnd_x     = sum_x + HALF;
    rnd_y     = sum_y + HALF;
    steps_dec = steps_left_r - 1'b1;
  end

  // Sign the quotient for the axis being finished
  always_comb begin
    quot_neg    = (state_r == dda_pkg::ST_DIV_X) ? neg_x_r : neg_y_r;
    quot_ext    = {1'b0, div_quot};
    quot_signed = quot_neg ? (INC_W'(0) - quot_ext) : quot_ext;
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    inc_x_nxt      = inc_x_r;
    inc_y_nxt      = inc_y_r;
    steps_left_nxt = steps_left_r;
    color_nxt      = color_r;
    active_nxt     = active_r;
    neg_x_nxt      = neg_x_r;
    neg_y_nxt      = neg_y_r;
    mag_y_nxt      = mag_y_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_pix_nxt    = out_pix_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    div_mag        = ax;
    div_den        = steps;
    case (state_r)
      dda_pkg::ST_IDLE: begin
        if (accept && in_tuser == dda_pkg::REQ_START) begin
          // Emit the start pixel and set up the new line
          color_nxt      = color_in;
          out_valid_nxt  = 1'b1;
          out_pix_nxt    = {color_in, y1, x1};
          out_last_nxt   = (steps == '0);
          acc_x_nxt      = {x1, {FRAC_BITS{1'b0}}};
          acc_y_nxt      = {y1, {FRAC_BITS{1'b0}}};
          steps_left_nxt = {1'b0, steps};
          neg_x_nxt      = (x2 < x1);
          neg_y_nxt      = (y2 < y1);
          mag_y_nxt      = ay;
          active_nxt     = (steps != '0);
          if (steps != '0) begin
            div_start = 1'b1;
            state_nxt = dda_pkg::ST_DIV_X;
          end
        end else if (accept && active_r) begin
          // Advance one pixel
          acc_x_nxt      = sum_x;
          acc_y_nxt      = sum_y;
          steps_left_nxt = steps_dec;
          out_valid_nxt  = 1'b1;
          out_pix_nxt    = {color_r, rnd_y[ACC_W-1:FRAC_BITS], rnd_x[ACC_W-1:FRAC_BITS]};
          out_last_nxt   = (steps_dec == '0);
          active_nxt     = (steps_dec != '0);
        end
      end
      dda_pkg::ST_DIV_X: begin
        div_mag = mag_y_r;
        div_den = steps_left_r[C-1:0];
        if (div_done) begin
          inc_x_nxt = quot_signed;
          div_start = 1'b1;
          state_nxt = dda_pkg::ST_DIV_Y;
        end
      end
      dda_pkg::ST_DIV_Y: begin
        div_mag = mag_y_r;
        div_den = steps_left_r[C-1:0];
        if (div_done) begin
          inc_y_nxt = quot_signed;
          state_nxt = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_x_r      <= acc_x_nxt;
    acc_y_r      <= acc_y_nxt;
    inc_x_r      <= inc_x_nxt;
    inc_y_r      <= inc_y_nxt;
    steps_left_r <= steps_left_nxt;
    color_r      <= color_nxt;
    neg_x_r      <= neg_x_nxt;
    neg_y_r      <= neg_y_nxt;
    mag_y_r      <= mag_y_nxt;
    out_pix_r    <= out_pix_nxt;
    out_last_r   <= out_last_nxt;
  end

  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-PIX_W){1'b0}}, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/dda_div.sv */
// Restoring divider: quot = (mag << FRAC_BITS) / den, for mag <= den, den != 0.
// One compare-and-subtract per cycle.
module dda_div #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] den_i,
  output logic                  done_o,
  output logic [FRAC_BITS:0]    quot_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic [FRAC_BITS:0]    quot_r, quot_nxt;
  logic                  ge;
  logic [COORD_BITS:0]   diff;

  // Shared compare-and-subtract step
  always_comb begin
    ge   = (rem_r >= {1'b0, den_r});
    diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  // Sequence the quotient bits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, mag_i};
      den_nxt  = den_i;
      quot_nxt = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[FRAC_BITS-1:0], ge};
      rem_nxt  = {diff[COORD_BITS-1:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

/* rtl/dda_chk.sv */
module dda_chk #(
  parameter  int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + dda_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  localparam int C = COORD_BITS;

  logic start_acc, same_ends;

  assign start_acc = in_tvalid && in_tready && (in_tuser == dda_pkg::REQ_START);
  assign same_ends = (in_tdata[C-1:0] == in_tdata[3*C-1:2*C]) &&
                     (in_tdata[2*C-1:C] == in_tdata[4*C-1:3*C]);

  // Hold a stalled pixel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel changed or dropped");

  // Start always yields its start pixel next cycle
  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> out_tvalid && out_tdata[C-1:0] == $past(in_tdata[C-1:0]) &&
                  out_tdata[2*C-1:C] == $past(in_tdata[2*C-1:C]))
    else $error("start pixel missing or wrong");

  // Start pixel ends the line only for equal endpoints
  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> out_tlast == $past(same_ends))
    else $error("start pixel last flag wrong");

  // Line setup holds off requests
  a_setup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc && !same_ends |=> !in_tready)
    else $error("request taken during line setup");

endmodule

bind dda_line_rasterizer_core dda_chk #(.COORD_BITS(COORD_BITS)) u_dda_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
